// File: hdl/tcspe_pkg.sv
// Package for the telecommand segment and packet extractor.
// Holds the shared types, codes and widths; no dependencies.
`default_nettype none
package tcspe_pkg;

	localparam int FLEN_W = 12;
	localparam int IDX_W  = 12;
	localparam int BLK_W  = 17;
	localparam int ALEN_W = 17;
	localparam int NSLOT  = 5;

	localparam logic [IDX_W-1:0] IDX_MAX     = {IDX_W{1'b1}};
	localparam int               SP_OVERHEAD = 7;

	localparam int MAX_PACKET_BYTES_DEF = 2048;
	localparam int MIN_BLOCK_BYTES_DEF  = 7;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef enum logic [1:0] {
		SEG_CONT  = 2'd0,
		SEG_FIRST = 2'd1,
		SEG_LAST  = 2'd2,
		SEG_WHOLE = 2'd3
	} seg_flags_t;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_COMMIT = 2'd1,
		KIND_ABORT  = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_ILLEGAL   = 3'd2,
		ST_CORRUPTED = 3'd3,
		ST_RESIDUAL  = 3'd4
	} status_t;

	// Slot positions inside one work record, in emission order.
	localparam int SLOT_DROP   = 0;
	localparam int SLOT_BYTE   = 1;
	localparam int SLOT_MID    = 2;
	localparam int SLOT_END    = 3;
	localparam int SLOT_STATUS = 4;

	// One classified input byte: which results it causes and their payload.
	typedef struct packed {
		logic [NSLOT-1:0] vld;
		kind_t            mid_kind;
		kind_t            end_kind;
		logic [7:0]       data;
		status_t          status;
	} rec_t;

endpackage
`default_nettype wire

// File: hdl/tcspe_queue.sv
// Short queue of work records between the front and back parts.
// Depends on tcspe_pkg for the record type and depth.
`default_nettype none
module tcspe_queue
	import tcspe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire rec_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output rec_t      rd_data,
	output logic      empty
);

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/tcspe_front.sv
// Front part: tracks frame and packet state per byte and classifies each byte
// into one work record. Depends on tcspe_pkg.
`default_nettype none
module tcspe_front
	import tcspe_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
	parameter int MIN_BLOCK_BYTES  = MIN_BLOCK_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [1:0]        seq_flags,
	input  wire logic [FLEN_W-1:0] frame_length,
	input  wire logic [7:0]        data_byte,
	input  wire logic              frame_first,
	input  wire logic              frame_last,
	output logic                   rec_push,
	output rec_t                   rec
);

	localparam logic [ALEN_W-1:0] MAX_L = ALEN_W'(MAX_PACKET_BYTES);
	localparam logic [FLEN_W-1:0] MIN_L = FLEN_W'(MIN_BLOCK_BYTES);

	seg_flags_t         prev_q;
	logic [ALEN_W-1:0]  alen_q;
	logic               open_q;
	logic [IDX_W-1:0]   fbi_q;
	logic [BLK_W-1:0]   bbi_q;
	logic [BLK_W-1:0]   bsize_q;
	logic [7:0]         hi_q;
	status_t            res_q;

	seg_flags_t         n_prev;
	logic [ALEN_W-1:0]  n_alen;
	logic               n_open;
	logic [IDX_W-1:0]   n_fbi;
	logic [BLK_W-1:0]   n_bbi;
	logic [BLK_W-1:0]   n_bsize;
	logic [7:0]         n_hi;
	status_t            n_res;

	always_comb begin
		seg_flags_t        flags;
		logic              drop;
		logic [ALEN_W-1:0] sum;
		logic [IDX_W-1:0]  idx;
		logic [IDX_W-1:0]  start;
		logic [BLK_W:0]    bi_inc;
		logic              bad;

		flags   = seg_flags_t'(seq_flags);
		n_prev  = prev_q;
		n_alen  = alen_q;
		n_open  = open_q;
		n_fbi   = fbi_q;
		n_bbi   = bbi_q;
		n_bsize = bsize_q;
		n_hi    = hi_q;
		n_res   = res_q;
		drop    = 1'b0;
		sum     = alen_q + ALEN_W'(frame_length);
		start   = '0;
		bi_inc  = '0;
		bad     = 1'b0;

		rec          = '0;
		rec.data     = data_byte;
		rec.mid_kind = KIND_COMMIT;
		rec.end_kind = KIND_COMMIT;

		// Frame start: open packet may be dropped, portion order and size checked.
		if (frame_first || fbi_q == '0) begin
			drop    = open_q && (bbi_q != '0 || flags == SEG_FIRST
				|| flags == SEG_WHOLE);
			n_fbi   = '0;
			n_res   = ST_OK;
			n_bbi   = '0;
			n_bsize = '0;
			if (flags == SEG_WHOLE) begin
				if (frame_length == '0) begin
					n_res = ST_CORRUPTED;
				end else if (ALEN_W'(frame_length) > MAX_L) begin
					n_res = ST_TOO_LARGE;
				end
			end else if (flags == SEG_FIRST) begin
				if (ALEN_W'(frame_length) > MAX_L) begin
					n_res  = ST_TOO_LARGE;
					n_alen = '0;
				end else begin
					n_alen = ALEN_W'(frame_length);
				end
			end else if (prev_q == SEG_FIRST || prev_q == SEG_CONT) begin
				if (sum > MAX_L) begin
					n_res  = ST_TOO_LARGE;
					n_alen = '0;
					drop   = open_q;
				end else begin
					n_alen = sum;
				end
			end else begin
				n_res  = ST_ILLEGAL;
				n_alen = '0;
				drop   = open_q;
			end
			if (drop) begin
				rec.vld[SLOT_DROP] = 1'b1;
				n_open = 1'b0;
			end
			if (flags != SEG_WHOLE && n_res == ST_OK) begin
				n_open = 1'b1;
			end
		end

		idx = n_fbi;

		if (flags != SEG_WHOLE) begin
			if (n_open && idx < frame_length) begin
				rec.vld[SLOT_BYTE] = 1'b1;
			end
		end else if (n_res == ST_OK && idx < frame_length) begin
			if (n_bbi == '0) begin
				if (frame_length - idx > MIN_L) begin
					n_open = 1'b1;
					rec.vld[SLOT_BYTE] = 1'b1;
					n_bbi = BLK_W'(1);
				end else begin
					n_res = ST_RESIDUAL;
				end
			end else begin
				rec.vld[SLOT_BYTE] = 1'b1;
				if (n_bbi == BLK_W'(4)) begin
					n_hi = data_byte;
				end
				if (n_bbi == BLK_W'(5)) begin
					start   = (idx >= IDX_W'(5)) ? idx - IDX_W'(5) : '0;
					n_bsize = BLK_W'({n_hi, data_byte}) + BLK_W'(SP_OVERHEAD);
					bad     = n_bsize > BLK_W'(frame_length - start);
				end
				if (bad) begin
					rec.vld[SLOT_MID] = 1'b1;
					rec.mid_kind = KIND_ABORT;
					n_open = 1'b0;
					n_bbi  = '0;
					n_res  = ST_CORRUPTED;
				end else begin
					bi_inc = {1'b0, n_bbi} + 1'b1;
					n_bbi  = bi_inc[BLK_W-1:0];
					if (bi_inc >= (BLK_W+1)'(6) && bi_inc == {1'b0, n_bsize}) begin
						rec.vld[SLOT_MID] = 1'b1;
						rec.mid_kind = KIND_COMMIT;
						n_open = 1'b0;
						n_bbi  = '0;
					end
				end
			end
		end

		if (frame_last) begin
			if (flags == SEG_WHOLE) begin
				if (n_open) begin
					rec.vld[SLOT_END] = 1'b1;
					rec.end_kind = KIND_ABORT;
					n_open = 1'b0;
					if (n_res == ST_OK) begin
						n_res = ST_CORRUPTED;
					end
				end
				if (n_res == ST_OK && ({1'b0, idx} + 1'b1) < {1'b0, frame_length}) begin
					n_res = ST_CORRUPTED;
				end
			end else if (flags == SEG_LAST && n_open) begin
				rec.vld[SLOT_END] = 1'b1;
				rec.end_kind = KIND_COMMIT;
				n_open = 1'b0;
				n_alen = '0;
			end
			rec.vld[SLOT_STATUS] = 1'b1;
			rec.status = n_res;
			n_prev  = flags;
			n_fbi   = '0;
			n_bbi   = '0;
			n_bsize = '0;
		end else begin
			n_fbi = (idx < IDX_MAX) ? idx + 1'b1 : IDX_MAX;
		end
	end

	assign rec_push = accept && (rec.vld != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= SEG_WHOLE;
			alen_q  <= '0;
			open_q  <= 1'b0;
			fbi_q   <= '0;
			bbi_q   <= '0;
			bsize_q <= '0;
			hi_q    <= '0;
			res_q   <= ST_OK;
		end else if (accept) begin
			prev_q  <= n_prev;
			alen_q  <= n_alen;
			open_q  <= n_open;
			fbi_q   <= n_fbi;
			bbi_q   <= n_bbi;
			bsize_q <= n_bsize;
			hi_q    <= n_hi;
			res_q   <= n_res;
		end
	end

endmodule
`default_nettype wire

// File: hdl/tcspe_back.sv
// Back part: walks the oldest record's slots, issues one result per cycle into
// the output register while it is empty or popped. Depends on tcspe_pkg.
`default_nettype none
module tcspe_back
	import tcspe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire rec_t head,
	input  wire logic head_valid,
	output logic      head_pop,
	input  wire logic pop,
	output logic      empty,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic [2:0] frame_status,
	output logic       run_last
);

	logic [NSLOT-1:0] done_q;
	logic             valid_q;
	kind_t            kind_q;
	logic [7:0]       byte_q;
	status_t          status_q;
	logic             last_q;

	logic [NSLOT-1:0] pending;
	logic [NSLOT-1:0] pick;
	logic             load;
	logic             is_last;
	kind_t            pick_kind;

	assign pending = head.vld & ~done_q;

	always_comb begin
		logic found;
		found = 1'b0;
		pick  = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (pending[i] && !found) begin
				pick[i] = 1'b1;
				found   = 1'b1;
			end
		end
	end

	always_comb begin
		pick_kind = KIND_BYTE;
		if (pick[SLOT_DROP]) begin
			pick_kind = KIND_ABORT;
		end else if (pick[SLOT_MID]) begin
			pick_kind = head.mid_kind;
		end else if (pick[SLOT_END]) begin
			pick_kind = head.end_kind;
		end else if (pick[SLOT_STATUS]) begin
			pick_kind = KIND_STATUS;
		end
	end

	assign is_last  = (pending & ~pick) == '0;
	assign load     = head_valid && (!valid_q || pop);
	assign head_pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				done_q <= is_last ? '0 : (done_q | pick);
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= pick_kind;
			byte_q   <= (pick_kind == KIND_BYTE) ? head.data : 8'd0;
			status_q <= (pick_kind == KIND_STATUS) ? head.status : ST_OK;
			last_q   <= is_last;
		end
	end

	assign empty        = !valid_q;
	assign out_kind     = kind_q;
	assign out_byte     = byte_q;
	assign frame_status = status_q;
	assign run_last     = last_q;

endmodule
`default_nettype wire

// File: hdl/tc_segment_packet_extractor_top.sv
// Top level of the telecommand segment and packet extractor.
// Depends on tcspe_pkg, tcspe_front, tcspe_queue and tcspe_back.
//
//   Channel  Direction  Handshake          Payload
//   input    in         push / full        seq_flags, frame_length, data_byte,
//                                          frame_first, frame_last
//   result   out        empty / pop        out_kind, out_byte, frame_status,
//                                          run_last
//
// The front part takes one byte per cycle while full is low and updates all
// frame and packet state in that same cycle, so a byte can follow in the next
// cycle. Each byte that causes results becomes one work record in a four-entry
// queue. The back part issues one result per cycle while its output is empty
// or popped; a byte causes one to four results, most bytes one. Result issue
// sets the sustained throughput. After reset the block is ready at once.
`default_nettype none
module tc_segment_packet_extractor_top
	import tcspe_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
	parameter int MIN_BLOCK_BYTES  = MIN_BLOCK_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [1:0]        seq_flags,
	input  wire logic [FLEN_W-1:0] frame_length,
	input  wire logic [7:0]        data_byte,
	input  wire logic              frame_first,
	input  wire logic              frame_last,
	output logic                   empty,
	input  wire logic              pop,
	output logic [1:0]             out_kind,
	output logic [7:0]             out_byte,
	output logic [2:0]             frame_status,
	output logic                   run_last
);

	logic accept;
	logic rec_push;
	rec_t rec;
	rec_t head;
	logic q_empty;
	logic head_pop;

	// A request is taken whenever the queue has room; full only reflects the
	// queue, so the front never stalls on a pending result by itself.
	assign accept = push && !full;

	tcspe_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES),
		.MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.seq_flags   (seq_flags),
		.frame_length(frame_length),
		.data_byte   (data_byte),
		.frame_first (frame_first),
		.frame_last  (frame_last),
		.rec_push    (rec_push),
		.rec         (rec)
	);

	// The queue decouples classification from result issue.
	tcspe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rec_push),
		.wr_data(rec),
		.full   (full),
		.rd_en  (head_pop),
		.rd_data(head),
		.empty  (q_empty)
	);

	// The back part owns the output register seen on the result ports.
	tcspe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (!q_empty),
		.head_pop    (head_pop),
		.pop         (pop),
		.empty       (empty),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.frame_status(frame_status),
		.run_last    (run_last)
	);

endmodule
`default_nettype wire
